### sv/hmac_sha1_one_time_code_core_assert.svh
// assertion macros shared by the rtl
`ifndef HMAC_SHA1_ONE_TIME_CODE_CORE_ASSERT_SVH
`define HMAC_SHA1_ONE_TIME_CODE_CORE_ASSERT_SVH

// same-cycle implication
`define HOTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define HOTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/hotp_pkg.sv
`default_nettype none
package hotp_pkg;
  localparam int KEY_BYTES_DEF = 64;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TIME = 2'd1;
  localparam logic [1:0] MODE_CNT  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] REG_EPOCH  = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_DIGITS = 2'd2;
  localparam logic [1:0] REG_KEYLEN = 2'd3;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;
  localparam logic [31:0] TRUNC_MASK = 32'h7FFF_FFFF;

  localparam logic [159:0] SHA1_IV =
    {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
  localparam logic [31:0] INNER_BITS = 32'd576;
  localparam logic [31:0] OUTER_BITS = 32'd672;

  typedef struct packed {
    logic init;
    logic go;
    logic push;
  } sha_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [31:0] pow10(input logic [3:0] d);
    logic [31:0] p;
    case (d) inside
      4'd0, 4'd1: p = 32'd10;
      4'd2: p = 32'd100;
      4'd3: p = 32'd1000;
      4'd4: p = 32'd10000;
      4'd5: p = 32'd100000;
      4'd6: p = 32'd1000000;
      4'd7: p = 32'd10000000;
      4'd8: p = 32'd100000000;
      default: p = 32'd1000000000;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

### sv/hotp_key.sv
`default_nettype none
module hotp_key #(
  parameter int KEY_BYTES = hotp_pkg::KEY_BYTES_DEF,
  localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [KW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [KW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);
  logic [7:0] mem [KEY_BYTES];
  logic [KEY_BYTES-1:0] vld_r;
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : 8'd0;
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

### sv/hotp_sha1.sv
`default_nettype none
module hotp_sha1 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hotp_pkg::sha_ctl_t ctl,
  input  wire logic [31:0]        word,
  output hotp_pkg::unit_sts_t     sts,
  output logic [159:0]            digest
);
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;
  logic        run_r, fin_r, done_r;
  logic [31:0] f, k, t, wn;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = hotp_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = hotp_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) ^ (b_r & d_r) ^ (c_r & d_r);
      k = hotp_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = hotp_pkg::K3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + w_r[0] + k;
    wn = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= fin_r;
      if (ctl.go && !run_r && !fin_r) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= word;
    end else if (run_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= {wn[30:0], wn[31]};
    end
    if (ctl.init) begin
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= hotp_pkg::SHA1_IV[159-32*i -: 32];
      end
    end else if (fin_r) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
    if (ctl.go && !run_r && !fin_r) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (run_r) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t;
    end
  end

  assign sts.busy = run_r | fin_r;
  assign sts.done = done_r;
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
endmodule
`default_nettype wire

### sv/hotp_div.sv
`default_nettype none
module hotp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [64:0] dividend,
  input  wire logic [31:0] divisor,
  output hotp_pkg::unit_sts_t sts,
  output logic [64:0]      quo,
  output logic [31:0]      rem
);
  logic [64:0] quo_r;
  logic [32:0] rem_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem_r[31:0], quo_r[64]};
  assign ge = sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'd64);
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (sh - {1'b0, dvs_r}) : sh;
      quo_r <= {quo_r[63:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo = quo_r;
  assign rem = rem_r[31:0];
endmodule
`default_nettype wire

### sv/hmac_sha1_one_time_code_core.sv
// hmac-sha1 one-time code core (hotp / totp)
// input stream: in_tuser carries mode, in_tdata key_index, key_byte, value.
// mode load writes one key byte and gives no result; an unused
// mode is dropped. time and counter modes each give one code on out_tdata.
// config writes go on the cfg channel (always ready); the user must make them
// only while the core is idle, as the core itself does not enforce this.
// a code takes two key blocks fed byte by byte from the key store, two
// message blocks, four sha-1 compressions on one round unit, and the shared
// 65-step serial divider, run for the decimal reduction and, in time mode,
// first for the time window as well.
// one item is in work at a time; in_tready is high only while idle.
// the code sits in an output register; a stalled receiver holds it there,
// the core takes one more item, works it and waits before posting its code.
// reset (rst_n low, synchronous) clears the key store to zero and sets
// epoch 0, time step 30, six digits and key length 20.
`default_nettype none
module hmac_sha1_one_time_code_core #(
  parameter int KEY_BYTES = hotp_pkg::KEY_BYTES_DEF,
  localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // key_index, key_byte, value
  input  wire logic [1:0]  in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // code
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  `include "hmac_sha1_one_time_code_core_assert.svh"

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_TDIV  = 12'b000000000010,
    S_IKEY  = 12'b000000000100,
    S_IH1   = 12'b000000001000,
    S_IMSG  = 12'b000000010000,
    S_IH2   = 12'b000000100000,
    S_OKEY  = 12'b000001000000,
    S_OH1   = 12'b000010000000,
    S_OMSG  = 12'b000100000000,
    S_OH2   = 12'b001000000000,
    S_MOD   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] epoch_r;
  logic [31:0] step_r;
  logic [3:0]  digits_r;
  logic [6:0]  klen_r;

  logic [63:0] ctr_r;
  logic        neg_r;
  logic [159:0] ihash_r;
  logic [23:0] acc_r;
  logic [6:0]  issue_r, rdpos_r;
  logic        rdv_r;
  logic [3:0]  wc_r;
  logic        init_r, go_r, divgo_r;
  logic [64:0] dvd_r;
  logic [31:0] dvs_r;
  logic [29:0] code_r;
  logic [29:0] out_code_r;
  logic        out_valid_r;

  logic [1:0]  in_mode;
  logic [5:0]  in_kidx;
  logic [7:0]  in_kbyte;
  logic [63:0] in_value;
  logic        acc;
  logic [63:0] diff, mag;
  logic [31:0] step_e;
  logic [6:0]  klen_e;
  logic        key_ph, msg_ph, key_start;
  logic [7:0]  kbyte, pad;
  logic [31:0] mword;
  logic        push;
  logic [159:0] dshift;
  logic [31:0] tval;

  hotp_pkg::sha_ctl_t  sha_ctl;
  hotp_pkg::unit_sts_t sha_sts, div_sts;
  logic [159:0] digest;
  logic [7:0]   key_rd;
  logic [64:0]  quo;
  logic [31:0]  rem;

  assign in_mode  = in_tuser;
  assign in_kidx  = in_tdata[5:0];
  assign in_kbyte = in_tdata[13:6];
  assign in_value = in_tdata[77:14];

  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign diff   = in_value - epoch_r;
  assign mag    = 64'd0 - diff;
  assign step_e = (step_r == 32'd0) ? 32'd1 : step_r;
  assign klen_e = (klen_r > 7'(KEY_BYTES)) ? 7'(KEY_BYTES) : klen_r;

  assign key_ph = (state_r == S_IKEY) || (state_r == S_OKEY);
  assign msg_ph = (state_r == S_IMSG) || (state_r == S_OMSG);
  assign key_start = (state_nxt == S_IKEY && state_r != S_IKEY) ||
                     (state_nxt == S_OKEY && state_r != S_OKEY);
  assign pad    = (state_r == S_IKEY) ? hotp_pkg::IPAD : hotp_pkg::OPAD;
  assign kbyte  = ((rdpos_r < klen_e) ? key_rd : 8'd0) ^ pad;

  always_comb begin
    mword = 32'd0;
    if (state_r == S_IMSG) begin
      case (wc_r)
        4'd0: mword = ctr_r[63:32];
        4'd1: mword = ctr_r[31:0];
        4'd2: mword = hotp_pkg::PAD_WORD;
        4'd15: mword = hotp_pkg::INNER_BITS;
        default: mword = 32'd0;
      endcase
    end else begin
      case (wc_r) inside
        [4'd0:4'd4]: mword = ihash_r[159-32*wc_r -: 32];
        4'd5: mword = hotp_pkg::PAD_WORD;
        4'd15: mword = hotp_pkg::OUTER_BITS;
        default: mword = 32'd0;
      endcase
    end
  end

  assign push = (key_ph && rdv_r && (rdpos_r[1:0] == 2'd3)) || msg_ph;

  assign sha_ctl.init = init_r;
  assign sha_ctl.go   = go_r;
  assign sha_ctl.push = push;

  assign dshift = digest << {digest[3:0], 3'b000};
  assign tval   = dshift[159:128] & hotp_pkg::TRUNC_MASK;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_mode == hotp_pkg::MODE_TIME) state_nxt = S_TDIV;
        else if (acc && in_mode == hotp_pkg::MODE_CNT) state_nxt = S_IKEY;
      end
      S_TDIV: if (div_sts.done) state_nxt = S_IKEY;
      S_IKEY: if (rdv_r && rdpos_r == 7'd63) state_nxt = S_IH1;
      S_IH1:  if (sha_sts.done) state_nxt = S_IMSG;
      S_IMSG: if (wc_r == 4'd15) state_nxt = S_IH2;
      S_IH2:  if (sha_sts.done) state_nxt = S_OKEY;
      S_OKEY: if (rdv_r && rdpos_r == 7'd63) state_nxt = S_OH1;
      S_OH1:  if (sha_sts.done) state_nxt = S_OMSG;
      S_OMSG: if (wc_r == 4'd15) state_nxt = S_OH2;
      S_OH2:  if (sha_sts.done) state_nxt = S_MOD;
      S_MOD:  if (div_sts.done) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      epoch_r     <= 64'd0;
      step_r      <= 32'd30;
      digits_r    <= 4'd6;
      klen_r      <= 7'd20;
      out_valid_r <= 1'b0;
      init_r      <= 1'b0;
      go_r        <= 1'b0;
      divgo_r     <= 1'b0;
      rdv_r       <= 1'b0;
      issue_r     <= '0;
      wc_r        <= '0;
    end else begin
      state_r <= state_nxt;
      init_r  <= key_start;
      go_r    <= (key_ph && rdv_r && rdpos_r == 7'd63) || (msg_ph && wc_r == 4'd15);
      divgo_r <= (state_r == S_IDLE && state_nxt == S_TDIV) ||
                 (state_r == S_OH2 && state_nxt == S_MOD);
      if (cfg_valid) begin
        unique case (cfg_index)
          hotp_pkg::REG_EPOCH:  epoch_r  <= cfg_data;
          hotp_pkg::REG_STEP:   step_r   <= cfg_data[31:0];
          hotp_pkg::REG_DIGITS: digits_r <= cfg_data[3:0];
          hotp_pkg::REG_KEYLEN: klen_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && state_nxt == S_IDLE) out_valid_r <= 1'b1;
      else if (out_tvalid && out_tready) out_valid_r <= 1'b0;
      if (key_start) begin
        issue_r <= '0;
        rdv_r   <= 1'b0;
      end else if (key_ph) begin
        rdv_r <= issue_r < 7'd64;
        if (issue_r < 7'd64) issue_r <= issue_r + 7'd1;
      end else begin
        rdv_r <= 1'b0;
      end
      if (msg_ph) wc_r <= wc_r + 4'd1;
      else wc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    rdpos_r <= issue_r;
    if (key_ph && rdv_r) acc_r <= {acc_r[15:0], kbyte};
    if (acc && in_mode == hotp_pkg::MODE_CNT) ctr_r <= in_value;
    if (acc && in_mode == hotp_pkg::MODE_TIME) begin
      neg_r <= diff[63];
      dvs_r <= step_e;
      dvd_r <= diff[63] ? ({1'b0, mag} + {33'd0, step_e} - 65'd1) : {1'b0, diff};
    end
    if (state_r == S_TDIV && div_sts.done) begin
      ctr_r <= neg_r ? (64'd0 - quo[63:0]) : quo[63:0];
    end
    if (state_r == S_IH2 && sha_sts.done) ihash_r <= digest;
    if (state_r == S_OH2 && sha_sts.done) begin
      dvd_r <= {33'd0, tval};
      dvs_r <= hotp_pkg::pow10(digits_r);
    end
    if (state_r == S_MOD && div_sts.done) code_r <= rem[29:0];
    if (state_r == S_DONE && state_nxt == S_IDLE) out_code_r <= code_r;
  end

  hotp_key #(.KEY_BYTES(KEY_BYTES)) u_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc && in_mode == hotp_pkg::MODE_LOAD && {26'd0, in_kidx} < KEY_BYTES),
    .wr_addr (in_kidx[KW-1:0]),
    .wr_data (in_kbyte),
    .rd_addr (issue_r[KW-1:0]),
    .rd_data (key_rd)
  );

  hotp_sha1 u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sha_ctl),
    .word   (key_ph ? {acc_r, kbyte} : mword),
    .sts    (sha_sts),
    .digest (digest)
  );

  hotp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (divgo_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .sts      (div_sts),
    .quo      (quo),
    .rem      (rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_code_r};

  `HOTP_ASSERT_NOW(a_sha_go_idle, go_r, !sha_sts.busy)
  `HOTP_ASSERT_NOW(a_div_go_idle, divgo_r, !div_sts.busy)
  `HOTP_ASSERT_NEXT(a_out_from_done, !out_valid_r && state_r != S_DONE, !out_valid_r)
  `HOTP_ASSERT_NOW(a_push_not_running, push, !sha_sts.busy)
endmodule
`default_nettype wire
